// ----- hdl/jsu_pkg.sv -----
// Shared types, codes and helper functions for the JSON string unescaper.
// No dependencies; imported by the decoder, the top level and the checker.
`default_nettype none

package jsu_pkg;

    // Result kind codes
    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_ESC   = 3'd1;
    localparam logic [2:0] ST_BAD_HEX   = 3'd2;
    localparam logic [2:0] ST_BAD_LEAD  = 3'd3;
    localparam logic [2:0] ST_NO_CONT   = 3'd4;
    localparam logic [2:0] ST_FIVE_LEAD = 3'd5;

    // Byte values with a meaning of their own
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_U         = 8'h75;

    localparam logic [15:0] REPLACEMENT_UNIT = 16'hFFFD;

    // Decoder mode
    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_ESCAPE = 3'd1,
        MODE_HEX    = 3'd2,
        MODE_CONT   = 3'd3,
        MODE_SKIP   = 3'd4
    } mode_t;

    // Decoder state carried from byte to byte
    typedef struct packed {
        mode_t       mode;
        logic [1:0]  left;
        logic [15:0] partial;
    } dec_state_t;

    // What one byte produces
    typedef struct packed {
        logic        has_result;
        logic        count_up;
        logic        clear;
        logic [1:0]  kind;
        logic [2:0]  status;
        logic [15:0] code_unit;
    } dec_res_t;

    // Hex digit value; bit 4 set means not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] v;
        v = 5'h10;
        if (b >= 8'h30 && b <= 8'h39) v = {1'b0, b[3:0]};
        else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66))
            v = {1'b0, b[3:0] + 4'd9};
        return v;
    endfunction

    // Simple escape translation; zero means not a valid escape
    function automatic logic [7:0] simple_escape(input logic [7:0] b);
        logic [7:0] e;
        unique case (b)
            CH_QUOTE:     e = CH_QUOTE;
            CH_SLASH:     e = CH_SLASH;
            CH_BACKSLASH: e = CH_BACKSLASH;
            8'h62:        e = 8'h08;
            8'h66:        e = 8'h0C;
            8'h6E:        e = 8'h0A;
            8'h72:        e = 8'h0D;
            8'h74:        e = 8'h09;
            default:      e = 8'h00;
        endcase
        return e;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/jsu_decode.sv -----
// Per-byte decode step: current decoder state and one byte in, next state and
// an optional result out. Pure combinational logic; depends on jsu_pkg.
`default_nettype none

module jsu_decode (
    input  wire logic [7:0]          in_byte,
    input  wire jsu_pkg::dec_state_t cur,
    output jsu_pkg::dec_state_t      nxt,
    output jsu_pkg::dec_res_t        res
);
    import jsu_pkg::*;

    logic [4:0]  hex_d;
    logic [7:0]  esc_v;
    logic [15:0] hex_acc;
    logic [15:0] cont_acc;

    assign hex_d    = hex_value(in_byte);
    assign esc_v    = simple_escape(in_byte);
    assign hex_acc  = {cur.partial[11:0], hex_d[3:0]};
    assign cont_acc = {cur.partial[9:0], in_byte[5:0]};

    always_comb
    begin
        nxt = cur;
        res = '0;

        unique case (cur.mode)
            // after a backslash
            MODE_ESCAPE:
            begin
                if (in_byte == CH_U)
                begin
                    nxt.mode    = MODE_HEX;
                    nxt.left    = 2'd3;
                    nxt.partial = '0;
                end
                else if (esc_v == 8'h00)
                begin
                    res.has_result = 1'b1;
                    res.clear      = 1'b1;
                    res.kind       = KIND_ERROR;
                    res.status     = ST_BAD_ESC;
                end
                else
                begin
                    res.has_result = 1'b1;
                    res.count_up   = 1'b1;
                    res.code_unit  = {8'h00, esc_v};
                end
            end

            // \uXXXX digits
            MODE_HEX:
            begin
                if (hex_d[4])
                begin
                    res.has_result = 1'b1;
                    res.clear      = 1'b1;
                    res.kind       = KIND_ERROR;
                    res.status     = ST_BAD_HEX;
                end
                else if (cur.left == 2'd0)
                begin
                    res.has_result = 1'b1;
                    res.count_up   = 1'b1;
                    res.code_unit  = hex_acc;
                end
                else
                begin
                    nxt.partial = hex_acc;
                    nxt.left    = cur.left - 2'd1;
                end
            end

            // UTF-8 continuation bytes
            MODE_CONT:
            begin
                if (in_byte[7:6] != 2'b10)
                begin
                    res.has_result = 1'b1;
                    res.clear      = 1'b1;
                    res.kind       = KIND_ERROR;
                    res.status     = ST_NO_CONT;
                end
                else if (cur.left <= 2'd1)
                begin
                    res.has_result = 1'b1;
                    res.count_up   = 1'b1;
                    res.code_unit  = cont_acc;
                end
                else
                begin
                    nxt.partial = cont_acc;
                    nxt.left    = cur.left - 2'd1;
                end
            end

            // tail of a four-byte sequence, dropped unchecked
            MODE_SKIP:
            begin
                if (cur.left <= 2'd1)
                begin
                    nxt.mode = MODE_NORMAL;
                    nxt.left = 2'd0;
                end
                else
                begin
                    nxt.left = cur.left - 2'd1;
                end
            end

            default:
            begin
                priority if (in_byte == CH_QUOTE)
                begin
                    res.has_result = 1'b1;
                    res.clear      = 1'b1;
                    res.kind       = KIND_END;
                    res.status     = ST_OK;
                end
                else if (in_byte == CH_BACKSLASH)
                begin
                    nxt.mode = MODE_ESCAPE;
                end
                else if (!in_byte[7])
                begin
                    res.has_result = 1'b1;
                    res.count_up   = 1'b1;
                    res.code_unit  = {8'h00, in_byte};
                end
                else if (in_byte[7:5] == 3'b110)
                begin
                    nxt.mode    = MODE_CONT;
                    nxt.left    = 2'd1;
                    nxt.partial = {11'd0, in_byte[4:0]};
                end
                else if (in_byte[7:4] == 4'b1110)
                begin
                    nxt.mode    = MODE_CONT;
                    nxt.left    = 2'd2;
                    nxt.partial = {12'd0, in_byte[3:0]};
                end
                else if (in_byte[7:3] == 5'b11110)
                begin
                    res.has_result = 1'b1;
                    res.count_up   = 1'b1;
                    res.code_unit  = REPLACEMENT_UNIT;
                    nxt.mode       = MODE_SKIP;
                    nxt.left       = 2'd3;
                    nxt.partial    = '0;
                end
                else if (in_byte[7:2] == 6'b111110)
                begin
                    res.has_result = 1'b1;
                    res.clear      = 1'b1;
                    res.kind       = KIND_ERROR;
                    res.status     = ST_FIVE_LEAD;
                end
                else
                begin
                    res.has_result = 1'b1;
                    res.clear      = 1'b1;
                    res.kind       = KIND_ERROR;
                    res.status     = ST_BAD_LEAD;
                end
            end
        endcase

        // a unit or a final result resets the sequence state, but a four-byte lead keeps the skip mode
        if (res.has_result)
        begin
            nxt.mode    = res.count_up && (nxt.mode == MODE_SKIP) ? MODE_SKIP : MODE_NORMAL;
            nxt.left    = (nxt.mode == MODE_SKIP) ? 2'd3 : 2'd0;
            nxt.partial = '0;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/json_string_unescape_utf16.sv -----
// Top level of the JSON string unescaper: input register, decode step,
// unit counter and result register. Depends on jsu_pkg and jsu_decode.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+-----------
//  in      | in_valid, in_stall, in_byte               | request in
//  out     | out_valid, out_stall, code_unit, kind,    | request out
//          | status, unit_count                        |
//
// One byte per cycle sustained while no byte with a result waits on a stalled
// output; a byte's result passes the input register, then the result register.
// Decode of a byte is a single pass through the decode step against the mode
// register. rst_n clears the mode, counter and both valid flags at once.
// A byte that gives no result moves on even while the output is stalled;
// a byte with a result waits in the input register until the result
// register is free.
`default_nettype none

module json_string_unescape_utf16 #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  in_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [15:0]      code_unit,
    output logic [1:0]       kind,
    output logic [2:0]       status,
    output logic [15:0]      unit_count
);
    import jsu_pkg::*;

    logic                   s1_valid_reg;
    logic [7:0]             s1_byte_reg;
    dec_state_t             state_reg;
    dec_state_t             state_next;
    dec_res_t               res;
    logic [COUNT_WIDTH-1:0] units_reg;
    logic [COUNT_WIDTH-1:0] units_next;
    logic [COUNT_WIDTH-1:0] units_inc;
    logic [COUNT_WIDTH-1:0] units_report;
    logic [31:0]            units_wide;
    logic                   out_valid_reg;
    logic [15:0]            code_unit_reg;
    logic [1:0]             kind_reg;
    logic [2:0]             status_reg;
    logic [15:0]            unit_count_reg;
    logic                   out_free;
    logic                   s1_consume;

    jsu_decode u_decode (
        .in_byte (s1_byte_reg),
        .cur     (state_reg),
        .nxt     (state_next),
        .res     (res)
    );

    // Handshake
    assign out_free   = !out_valid_reg || !out_stall;
    assign s1_consume = s1_valid_reg && (!res.has_result || out_free);
    assign in_stall   = s1_valid_reg && !s1_consume;

    // Saturating unit counter
    assign units_inc    = (units_reg == '1) ? units_reg : units_reg + 1'b1;
    assign units_report = res.count_up ? units_inc : units_reg;
    assign units_next   = res.clear ? '0 : units_report;
    assign units_wide   = 32'(units_report);

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_byte_reg <= in_byte;
        end
    end

    // Decoder state and counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{mode: MODE_NORMAL, left: 2'd0, partial: 16'd0};
            units_reg <= '0;
        end
        else if (s1_consume)
        begin
            state_reg <= state_next;
            units_reg <= units_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_consume && res.has_result;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s1_consume && res.has_result)
        begin
            code_unit_reg  <= res.code_unit;
            kind_reg       <= res.kind;
            status_reg     <= res.status;
            unit_count_reg <= units_wide[15:0];
        end
    end

    assign out_valid  = out_valid_reg;
    assign code_unit  = code_unit_reg;
    assign kind       = kind_reg;
    assign status     = status_reg;
    assign unit_count = unit_count_reg;

endmodule

`default_nettype wire

// ----- hdl/jsu_checker.sv -----
// Port-level checks for the JSON string unescaper, bound to the top level.
// Depends on jsu_pkg and json_string_unescape_utf16.
`default_nettype none

module jsu_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [15:0] code_unit,
    input wire logic [1:0]  kind,
    input wire logic [2:0]  status
);
    import jsu_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(code_unit) && $stable(kind)
            && $stable(status))
        else $error("stalled result changed");

    // characters and ends carry ok status
    a_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_CHAR || kind == KIND_END) |-> status == ST_OK)
        else $error("non-error result with error status");

    // errors carry a cause
    a_err_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_ERROR |-> status != ST_OK)
        else $error("error result without a cause");

    // final results carry no code unit
    a_final_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_CHAR |-> code_unit == 16'd0)
        else $error("end or error result with a code unit");

endmodule

bind json_string_unescape_utf16 jsu_checker u_jsu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .code_unit (code_unit),
    .kind      (kind),
    .status    (status)
);

`default_nettype wire
